/* hw/rtl/lrf_pkg.sv */
// lrf_pkg: constants, register indexes and shared types for the language range filter
// used by language_range_filter and tb; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package lrf_pkg;

  localparam int unsigned MAX_RANGE_BYTES = 32;
  localparam int unsigned RB_AW           = $clog2(MAX_RANGE_BYTES);
  localparam int unsigned LEN_W           = 6;

  localparam logic [7:0] STAR_CHAR   = 8'h2A;
  localparam logic [7:0] HYPHEN_CHAR = 8'h2D;

  typedef enum logic [2:0] {
    CFG_CHARS_0_7    = 3'd0,
    CFG_CHARS_8_15   = 3'd1,
    CFG_CHARS_16_23  = 3'd2,
    CFG_CHARS_24_31  = 3'd3,
    CFG_RANGE_LENGTH = 3'd4,
    CFG_BASIC_MODE   = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [RB_AW-1:0] range_start;
    logic [7:0]       tag_len;
    logic             subtag_eq;
    logic             first_subtag;
    logic             failed;
    logic             range_done;
    logic [7:0]       tag_pos;
  } tag_state_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/language_range_filter.sv */
// language_range_filter: streaming matcher of a language tag against a configured range
// depends on lrf_pkg (constants, register indexes, state struct, case folding)
`timescale 1ns / 1ps
`default_nettype none

// Takes one tag byte per cycle on in_* unless the output is held (tlast marks the tag's
// final byte) and gives one result item, the match verdict, for each tag in the cycle
// after its last byte is taken. The range's per-position tables (subtag ends, wildcard
// skips) are rebuilt in two register stages from the configuration registers; after
// reset and after each write to a known register in_tready stays low while they are
// rebuilt. A write to a known register restarts the tag in progress.
module language_range_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] tag_byte
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tlast,
  // out_tdata: [0] matched, [7:1] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int unsigned NB    = lrf_pkg::MAX_RANGE_BYTES;
  localparam int unsigned AW    = lrf_pkg::RB_AW;
  localparam int unsigned LW    = lrf_pkg::LEN_W;
  localparam int unsigned NSKIP = NB + 2;

  localparam lrf_pkg::tag_state_t TAG_RESET = '{
    range_start: '0, tag_len: 8'd0, subtag_eq: 1'b1, first_subtag: 1'b1,
    failed: 1'b0, range_done: 1'b0, tag_pos: 8'd0};

  // configuration registers
  logic [63:0]   range_word_r [4];
  logic [LW-1:0] range_length_r;
  logic          basic_mode_r;
  logic [1:0]    stall_r;

  logic cfg_acc, cfg_hit, in_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_tready = (stall_r == 2'd0) && (!out_tvalid || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    unique case (cfg_index) inside
      lrf_pkg::CFG_CHARS_0_7, lrf_pkg::CFG_CHARS_8_15, lrf_pkg::CFG_CHARS_16_23,
      lrf_pkg::CFG_CHARS_24_31, lrf_pkg::CFG_RANGE_LENGTH,
      lrf_pkg::CFG_BASIC_MODE: cfg_hit = 1'b1;
      default:                 cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_word_r[0] <= 64'd42;
      range_word_r[1] <= 64'd0;
      range_word_r[2] <= 64'd0;
      range_word_r[3] <= 64'd0;
      range_length_r  <= LW'(1);
      basic_mode_r    <= 1'b0;
      stall_r         <= 2'd2;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index) inside
          lrf_pkg::CFG_CHARS_0_7, lrf_pkg::CFG_CHARS_8_15, lrf_pkg::CFG_CHARS_16_23,
          lrf_pkg::CFG_CHARS_24_31: range_word_r[cfg_index[1:0]] <= cfg_data;
          lrf_pkg::CFG_RANGE_LENGTH: range_length_r <= cfg_data[LW-1:0];
          lrf_pkg::CFG_BASIC_MODE:   basic_mode_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (cfg_acc && cfg_hit) begin
        stall_r <= 2'd2;
      end else if (stall_r != 2'd0) begin
        stall_r <= stall_r - 2'd1;
      end
    end
  end

  // table stage 1: folded bytes, hyphen and whole-subtag wildcard masks
  logic [8*(NB+1)-1:0] range_flat;
  logic [LW-1:0]       n_c;
  logic [7:0]          fold_nxt [NB];
  logic [NB-1:0]       hyph_nxt, wild_nxt;
  logic                star_only_nxt;

  logic [7:0]    fold_r [NB];
  logic [NB-1:0] hyph_r, wild_r;
  logic [LW-1:0] n_r;
  logic          star_only_r;

  assign range_flat = {8'h00, range_word_r[3], range_word_r[2],
                       range_word_r[1], range_word_r[0]};
  assign n_c = (range_length_r > LW'(NB)) ? LW'(NB) : range_length_r;

  always_comb begin
    logic [7:0] cur, nx;
    logic       in_rng, end_after;
    for (int i = 0; i < NB; i++) begin
      cur       = range_flat[8*i +: 8];
      nx        = range_flat[8*(i+1) +: 8];
      in_rng    = LW'(i) < n_c;
      end_after = (LW'(i + 1) >= n_c) || (nx == lrf_pkg::HYPHEN_CHAR);
      fold_nxt[i] = lrf_pkg::fold(cur);
      hyph_nxt[i] = in_rng && (cur == lrf_pkg::HYPHEN_CHAR);
      wild_nxt[i] = in_rng && (cur == lrf_pkg::STAR_CHAR) && end_after;
    end
    star_only_nxt = (n_c == LW'(1)) && (range_flat[7:0] == lrf_pkg::STAR_CHAR);
  end

  always_ff @(posedge clk) begin
    fold_r      <= fold_nxt;
    hyph_r      <= hyph_nxt;
    wild_r      <= wild_nxt;
    n_r         <= n_c;
    star_only_r <= star_only_nxt;
  end

  // table stage 2: subtag end and next range subtag (past wildcards) per start
  logic [LW-1:0] end_nxt  [NB];
  logic [AW-1:0] next_nxt [NB];
  logic [NB-1:0] done_nxt;
  logic [AW-1:0] skip_q    [NSKIP];
  logic [NSKIP-1:0] skip_done;

  logic [LW-1:0] end_r  [NB];
  logic [AW-1:0] next_r [NB];
  logic [NB-1:0] done_r;

  always_comb begin
    logic          found;
    logic [AW-1:0] q;
    logic [LW-1:0] e, p;
    for (int pi = 0; pi < NSKIP; pi++) begin
      found = 1'b0;
      q     = '0;
      for (int k = NB - 1; k >= 0; k--) begin
        if (k >= pi && ((k - pi) % 2 == 0) && !wild_r[k]) begin
          found = 1'b1;
          q     = AW'(k);
        end
      end
      skip_q[pi]    = q;
      skip_done[pi] = !found || ({1'b0, q} >= n_r);
    end
    for (int s = 0; s < NB; s++) begin
      e = n_r;
      for (int i = NB - 1; i >= 0; i--) begin
        if (i >= s && hyph_r[i]) begin
          e = LW'(i);
        end
      end
      p           = e + LW'(1);
      end_nxt[s]  = e;
      next_nxt[s] = skip_q[p];
      done_nxt[s] = skip_done[p];
    end
  end

  always_ff @(posedge clk) begin
    end_r  <= end_nxt;
    next_r <= next_nxt;
    done_r <= done_nxt;
  end

  // per-item matching
  lrf_pkg::tag_state_t st_r, st_nxt;
  logic [7:0]    tb, fb, rb;
  logic          is_hyph, ok_nxt;
  logic [8:0]    p9;
  logic [LW-1:0] e_cur, sub_len;
  logic [AW-1:0] rd_idx;
  logic [7:0]    n8;

  assign tb      = in_tdata[7:0];
  assign fb      = lrf_pkg::fold(tb);
  assign is_hyph = (tb == lrf_pkg::HYPHEN_CHAR);
  assign p9      = {{(9-AW){1'b0}}, st_r.range_start} + {1'b0, st_r.tag_len};
  assign e_cur   = end_r[st_r.range_start];
  assign sub_len = e_cur - {{(LW-AW){1'b0}}, st_r.range_start};
  assign n8      = {{(8-LW){1'b0}}, n_r};
  assign rd_idx  = basic_mode_r ? st_r.tag_pos[AW-1:0] : p9[AW-1:0];
  assign rb      = fold_r[rd_idx];

  always_comb begin
    logic same, adv, fail;
    st_nxt = st_r;
    same   = 1'b0;
    adv    = 1'b0;
    fail   = 1'b0;
    if (basic_mode_r) begin
      if (!st_r.failed) begin
        if (st_r.tag_pos < n8) begin
          if (rb != fb) st_nxt.failed = 1'b1;
        end else if (st_r.tag_pos == n8) begin
          if (!is_hyph) st_nxt.failed = 1'b1;
        end
      end
      if (st_r.tag_pos != 8'hFF) st_nxt.tag_pos = st_r.tag_pos + 8'd1;
      ok_nxt = !st_nxt.failed && (st_nxt.tag_pos >= n8);
    end else begin
      if (!is_hyph) begin
        if (!st_r.failed && !st_r.range_done &&
            ((p9 >= {3'b000, e_cur}) || (rb != fb))) begin
          st_nxt.subtag_eq = 1'b0;
        end
        if (st_r.tag_len != 8'hFF) st_nxt.tag_len = st_r.tag_len + 8'd1;
      end
      if (is_hyph || in_tlast) begin
        same = st_nxt.subtag_eq && (st_nxt.tag_len == {2'b00, sub_len});
        if (!st_r.failed && !st_r.range_done) begin
          if (st_r.first_subtag) begin
            if (wild_r[st_r.range_start] || same) adv = 1'b1;
            else fail = 1'b1;
          end else if (same) begin
            adv = 1'b1;
          end else if (st_nxt.tag_len == 8'd1) begin
            fail = 1'b1;
          end
        end
        if (adv) begin
          if (done_r[st_r.range_start]) st_nxt.range_done = 1'b1;
          else st_nxt.range_start = next_r[st_r.range_start];
        end
        if (fail) st_nxt.failed = 1'b1;
        st_nxt.tag_len      = 8'd0;
        st_nxt.subtag_eq    = 1'b1;
        st_nxt.first_subtag = 1'b0;
      end
      ok_nxt = !st_nxt.failed && st_nxt.range_done;
    end
    if (star_only_r) ok_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= TAG_RESET;
      out_tvalid <= 1'b0;
    end else begin
      if (cfg_acc && cfg_hit) begin
        st_r <= TAG_RESET;
      end else if (in_acc) begin
        st_r <= in_tlast ? TAG_RESET : st_nxt;
      end
      if (in_acc && in_tlast) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      out_tdata <= {7'd0, ok_nxt};
    end
  end

`ifndef SYNTHESIS
  // a write to a known register restarts the tag
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_hit |=> st_r.first_subtag && st_r.tag_len == 8'd0 &&
      !st_r.failed && !st_r.range_done && st_r.tag_pos == 8'd0)
    else $error("tag state not cleared after configuration write");

  // a live range subtag always starts inside the range
  a_start_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !basic_mode_r && !st_r.first_subtag && !st_r.range_done && !st_r.failed |->
      {{(LW-AW){1'b0}}, st_r.range_start} < n_r)
    else $error("range subtag start beyond range length");

  // every last byte gives a verdict next cycle
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no verdict after last byte");
`endif

endmodule

`default_nettype wire

/* verif/tb.sv */
// tb: self-checking bench for language_range_filter, streams language tags against
// ranges in basic and extended mode and checks each verdict against a built-in predictor
// depends on lrf_pkg and language_range_filter
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int MAX_WAIT = 17;
  localparam logic [2:0] CFG_SPARE_6 = 3'd6;
  localparam logic [2:0] CFG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [63:0] data;   // tag byte in [7:0] for an item
    logic        last;
  } action_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] tag_byte
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // [0] matched, [7:1] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [63:0] cfg_data = 64'd0;

  language_range_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // no idling on either side while bits 8:7 of the cycle counter are zero
  function automatic int pick_wait();
    if (cycle_count[8:7] == 2'b00) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // ---------------------------------------------------------------------------
  // verdict predictor
  // ---------------------------------------------------------------------------
  logic [63:0] range_regs [4];
  logic [5:0]  len_reg;
  logic        basic_reg;
  int          cur_start;
  int          sub_len;
  bit          sub_same;
  bit          in_first;
  bit          tag_failed;
  bit          range_spent;
  int          tag_count;

  function automatic void restart_tag();
    cur_start = 0;
    sub_len = 0;
    sub_same = 1'b1;
    in_first = 1'b1;
    tag_failed = 1'b0;
    range_spent = 1'b0;
    tag_count = 0;
  endfunction

  function automatic int usable_len();
    return (len_reg > lrf_pkg::MAX_RANGE_BYTES) ? lrf_pkg::MAX_RANGE_BYTES : int'(len_reg);
  endfunction

  function automatic logic [7:0] range_char(int i);
    logic [63:0] w;
    if (i >= lrf_pkg::MAX_RANGE_BYTES) return 8'h00;
    w = range_regs[i / 8] >> (8 * (i % 8));
    return w[7:0];
  endfunction

  function automatic logic [7:0] lower_ascii(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic int subtag_stop(int s, int n);
    int e;
    e = s;
    while (e < n && range_char(e) != lrf_pkg::HYPHEN_CHAR) e++;
    return e;
  endfunction

  function automatic bit star_subtag(int s, int n);
    return s < n && range_char(s) == lrf_pkg::STAR_CHAR && subtag_stop(s, n) == s + 1;
  endfunction

  // step to the next range subtag, passing over whole-subtag wildcards
  function automatic void next_subtag(int n);
    int s;
    int e;
    s = cur_start;
    for (int g = 0; g <= lrf_pkg::MAX_RANGE_BYTES; g++) begin
      e = subtag_stop(s, n);
      if (e + 1 >= n) begin
        range_spent = 1'b1;
        return;
      end
      s = e + 1;
      if (!star_subtag(s, n)) break;
    end
    cur_start = s;
  endfunction

  function automatic void end_tag_subtag(int n);
    int s;
    int e;
    bit same;
    if (!tag_failed && !range_spent) begin
      s = cur_start;
      e = subtag_stop(s, n);
      same = sub_same && sub_len == e - s;
      if (in_first) begin
        if (star_subtag(s, n) || same) next_subtag(n);
        else tag_failed = 1'b1;
      end else if (same) begin
        next_subtag(n);
      end else if (sub_len == 1) begin
        // an unmatched singleton cannot be passed over
        tag_failed = 1'b1;
      end
    end
    sub_len = 0;
    sub_same = 1'b1;
    in_first = 1'b0;
  endfunction

  function automatic bit predict_verdict(input logic [7:0] b, input bit last,
                                         output bit verdict);
    int n;
    int p;
    int e;
    bit ok;
    n = usable_len();
    if (basic_reg) begin
      if (!tag_failed) begin
        if (tag_count < n) begin
          if (lower_ascii(range_char(tag_count)) != lower_ascii(b)) tag_failed = 1'b1;
        end else if (tag_count == n) begin
          if (b != lrf_pkg::HYPHEN_CHAR) tag_failed = 1'b1;
        end
      end
      if (tag_count < 255) tag_count++;
      ok = !tag_failed && tag_count >= n;
    end else begin
      if (b == lrf_pkg::HYPHEN_CHAR) begin
        end_tag_subtag(n);
      end else begin
        if (!tag_failed && !range_spent) begin
          p = cur_start + sub_len;
          e = subtag_stop(cur_start, n);
          if (p >= e || lower_ascii(range_char(p)) != lower_ascii(b)) sub_same = 1'b0;
        end
        if (sub_len < 255) sub_len++;
        if (last) end_tag_subtag(n);
      end
      ok = !tag_failed && range_spent;
    end
    verdict = 1'b0;
    if (!last) return 1'b0;
    if (n == 1 && range_char(0) == lrf_pkg::STAR_CHAR) ok = 1'b1;
    verdict = ok;
    restart_tag();
    return 1'b1;
  endfunction

  function automatic void write_register(logic [2:0] idx, logic [63:0] v);
    case (idx) inside
      lrf_pkg::CFG_CHARS_0_7, lrf_pkg::CFG_CHARS_8_15, lrf_pkg::CFG_CHARS_16_23,
      lrf_pkg::CFG_CHARS_24_31: begin
        range_regs[idx[1:0]] = v;
        restart_tag();
      end
      lrf_pkg::CFG_RANGE_LENGTH: begin
        len_reg = v[5:0];
        restart_tag();
      end
      lrf_pkg::CFG_BASIC_MODE: begin
        basic_reg = v[0];
        restart_tag();
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // checker: predicts on accepted items, compares accepted verdicts
  // ---------------------------------------------------------------------------
  logic expected_verdicts [$];
  int   mismatches = 0;
  int   calm_cycles;
  logic settled = 1'b0;
  bit   verdict_now;
  logic verdict_want;

  always @(posedge clk) begin
    if (!rst_n) begin
      range_regs[0] = 64'd42;
      range_regs[1] = 64'd0;
      range_regs[2] = 64'd0;
      range_regs[3] = 64'd0;
      len_reg = 6'd1;
      basic_reg = 1'b0;
      restart_tag();
      expected_verdicts.delete();
      calm_cycles = 0;
      settled <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        if (predict_verdict(in_tdata, in_tlast, verdict_now))
          expected_verdicts.push_back(verdict_now);
      end
      if (out_tvalid && out_tready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict item, expected none, got %h", $time, out_tdata);
          mismatches++;
        end else begin
          verdict_want = expected_verdicts.pop_front();
          if (out_tdata !== {7'd0, verdict_want}) begin
            $display("%0t: verdict mismatch, expected %h, got %h", $time,
                     {7'd0, verdict_want}, out_tdata);
            mismatches++;
          end
        end
      end
      if ((in_tvalid && in_tready) || out_tvalid) calm_cycles = 0;
      else if (calm_cycles < 1000) calm_cycles++;
      settled <= (expected_verdicts.size() == 0) && calm_cycles >= 4;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver with random stalls and one long hold-off
  // ---------------------------------------------------------------------------
  int recv_wait;
  int results_taken;
  bit long_hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait = 0;
      results_taken = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_taken++;
        if (results_taken == 30 && !long_hold_done) begin
          // long stall so the block backs up and stalls its input
          recv_wait = 400;
          long_hold_done = 1'b1;
        end else begin
          recv_wait = pick_wait();
        end
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_tready <= (recv_wait == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // sender: items and register writes, writes only once the block is quiet
  // ---------------------------------------------------------------------------
  action_t plan [$];
  action_t next_act;
  int      send_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      send_gap = 0;
    end else if (!(in_tvalid && !in_tready) && !(cfg_valid && !cfg_ready)) begin
      if (send_gap > 0 || plan.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
      end else begin
        next_act = plan[0];
        if (next_act.is_cfg) begin
          in_tvalid <= 1'b0;
          if (settled && !in_tvalid) begin
            void'(plan.pop_front());
            cfg_valid <= 1'b1;
            cfg_index <= next_act.idx;
            cfg_data <= next_act.data;
            send_gap = pick_wait();
          end else begin
            cfg_valid <= 1'b0;
          end
        end else begin
          void'(plan.pop_front());
          in_tvalid <= 1'b1;
          in_tdata <= next_act.data[7:0];
          in_tlast <= next_act.last;
          cfg_valid <= 1'b0;
          send_gap = pick_wait();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------
  logic [7:0] gen_range_bytes [32];
  int         gen_range_n;
  logic [5:0] gen_len;
  logic       gen_basic;
  logic [7:0] tag_buf [$];
  int         tag_items;

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 35);
    if (r < 26) return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + r[7:0];
    return 8'h30 + (r[7:0] - 8'd26);
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1))
      return c ^ 8'h20;
    return c;
  endfunction

  function automatic void range_put(logic [7:0] c);
    if (gen_range_n < lrf_pkg::MAX_RANGE_BYTES) begin
      gen_range_bytes[gen_range_n] = c;
      gen_range_n++;
    end
  endfunction

  task automatic queue_write(logic [2:0] idx, logic [63:0] v);
    action_t a;
    a = '0;
    a.is_cfg = 1'b1;
    a.idx = idx;
    a.data = v;
    plan.push_back(a);
  endtask

  task automatic queue_range();
    logic [63:0] w [4];
    for (int k = 0; k < lrf_pkg::MAX_RANGE_BYTES; k++)
      w[k / 8][8 * (k % 8) +: 8] = gen_range_bytes[k];
    queue_write(lrf_pkg::CFG_CHARS_0_7, w[0]);
    queue_write(lrf_pkg::CFG_CHARS_8_15, w[1]);
    queue_write(lrf_pkg::CFG_CHARS_16_23, w[2]);
    queue_write(lrf_pkg::CFG_CHARS_24_31, w[3]);
    queue_write(lrf_pkg::CFG_RANGE_LENGTH, {58'd0, gen_len});
    queue_write(lrf_pkg::CFG_BASIC_MODE, {63'd0, gen_basic});
  endtask

  // a write in the middle of a tag restarts it, unless the index is unused
  task automatic queue_restart();
    case ($urandom_range(0, 3))
      0: queue_write(lrf_pkg::CFG_RANGE_LENGTH, {58'd0, gen_len});
      1: queue_write(lrf_pkg::CFG_BASIC_MODE, {63'd0, gen_basic});
      2: queue_write(CFG_SPARE_6, {$urandom, $urandom});
      default: queue_write(CFG_SPARE_7, {$urandom, $urandom});
    endcase
  endtask

  task automatic queue_tag();
    action_t a;
    int cut;
    if (tag_buf.size() == 0) tag_buf.push_back(rand_alnum());
    cut = ($urandom_range(0, 24) == 0) ? int'($urandom_range(0, tag_buf.size() - 1)) : -1;
    for (int k = 0; k < tag_buf.size(); k++) begin
      a = '0;
      a.data[7:0] = tag_buf[k];
      a.last = (k == tag_buf.size() - 1);
      plan.push_back(a);
      if (k == cut && !a.last) queue_restart();
    end
    tag_items += tag_buf.size();
  endtask

  task automatic load_range_str(string s);
    for (int k = 0; k < lrf_pkg::MAX_RANGE_BYTES; k++)
      gen_range_bytes[k] = 8'($urandom_range(0, 255));
    for (int k = 0; k < s.len(); k++) gen_range_bytes[k] = s[k];
    gen_range_n = s.len();
    gen_len = 6'(s.len());
  endtask

  task automatic load_tag_str(string s);
    tag_buf.delete();
    for (int k = 0; k < s.len(); k++) tag_buf.push_back(s[k]);
  endtask

  task automatic gen_range();
    int nsub;
    int len;
    for (int k = 0; k < lrf_pkg::MAX_RANGE_BYTES; k++)
      gen_range_bytes[k] = 8'($urandom_range(0, 255));
    gen_range_n = 0;
    case ($urandom_range(0, 9))
      0: range_put(lrf_pkg::STAR_CHAR);
      1: begin
        // arbitrary bytes with some hyphens
        gen_range_n = $urandom_range(1, lrf_pkg::MAX_RANGE_BYTES);
        for (int k = 0; k < gen_range_n; k++)
          if ($urandom_range(0, 3) == 0) gen_range_bytes[k] = lrf_pkg::HYPHEN_CHAR;
      end
      2: begin
        // full-width range, ends in a hyphen
        for (int k = 0; k < lrf_pkg::MAX_RANGE_BYTES; k++)
          range_put((k % 8 == 7) ? lrf_pkg::HYPHEN_CHAR : rand_alnum());
      end
      default: begin
        nsub = $urandom_range(1, 4);
        for (int k = 0; k < nsub; k++) begin
          if (k > 0) range_put(lrf_pkg::HYPHEN_CHAR);
          case ($urandom_range(0, 7))
            0: range_put(lrf_pkg::STAR_CHAR);
            1: begin
              // star that is not a whole subtag
              range_put(rand_alnum());
              range_put(lrf_pkg::STAR_CHAR);
            end
            default: begin
              len = (k == 0) ? $urandom_range(1, 3) : $urandom_range(1, 8);
              repeat (len) range_put(rand_alnum());
            end
          endcase
        end
        if ($urandom_range(0, 9) == 0) range_put(lrf_pkg::HYPHEN_CHAR);
      end
    endcase
  endtask

  task automatic push_subtag();
    int len;
    len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 8);
    repeat (len) tag_buf.push_back(rand_alnum());
  endtask

  // builds a tag that mostly follows the current range
  task automatic gen_tag(bit literal);
    int s;
    int e;
    int sub;
    int keep;
    tag_buf.delete();
    if (literal) begin
      for (int k = 0; k < gen_range_n; k++) tag_buf.push_back(flip_case(gen_range_bytes[k]));
    end else begin
      s = 0;
      sub = 0;
      while (s < gen_range_n) begin
        e = s;
        while (e < gen_range_n && gen_range_bytes[e] != lrf_pkg::HYPHEN_CHAR) e++;
        if (sub > 0) tag_buf.push_back(lrf_pkg::HYPHEN_CHAR);
        if (sub > 0 && $urandom_range(0, 3) == 0) begin
          push_subtag();
          tag_buf.push_back(lrf_pkg::HYPHEN_CHAR);
        end
        if (e == s + 1 && gen_range_bytes[s] == lrf_pkg::STAR_CHAR) begin
          push_subtag();
        end else begin
          for (int k = s; k < e; k++)
            tag_buf.push_back(($urandom_range(0, 19) == 0) ? rand_alnum()
                                                            : flip_case(gen_range_bytes[k]));
        end
        s = e + 1;
        sub++;
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      tag_buf.push_back(lrf_pkg::HYPHEN_CHAR);
      push_subtag();
    end
    if ($urandom_range(0, 11) == 0) begin
      // doubled hyphen gives an empty subtag
      tag_buf.push_back(lrf_pkg::HYPHEN_CHAR);
      tag_buf.push_back(lrf_pkg::HYPHEN_CHAR);
      push_subtag();
    end
    if (tag_buf.size() > 1 && $urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, tag_buf.size() - 1);
      while (tag_buf.size() > keep) void'(tag_buf.pop_back());
    end
    if ($urandom_range(0, 11) == 0) tag_buf.push_back(lrf_pkg::HYPHEN_CHAR);
  endtask

  task automatic gen_noise_tag();
    tag_buf.delete();
    repeat ($urandom_range(1, 10))
      tag_buf.push_back(($urandom_range(0, 4) == 0) ? lrf_pkg::HYPHEN_CHAR
                                                    : 8'($urandom_range(0, 255)));
  endtask

  int phase;
  int pick;

  initial begin
    tag_items = 0;

    // reset range is a lone star: anything matches, byte extremes
    tag_buf.delete();
    tag_buf.push_back(8'h00);
    tag_buf.push_back(8'hFF);
    queue_tag();

    // extended: wildcard skipped, unmatched subtag passed over, singleton fails
    load_range_str("en-*-us");
    gen_basic = 1'b0;
    queue_range();
    load_tag_str("EN-ab-uS");
    queue_tag();
    load_tag_str("en-x");
    queue_tag();

    // basic: prefix followed by a trailing hyphen, then tag too short
    load_range_str("de");
    gen_basic = 1'b1;
    queue_range();
    load_tag_str("DE-");
    queue_tag();
    load_tag_str("d");
    queue_tag();

    // empty range in extended mode needs an empty first subtag
    gen_len = 6'd0;
    queue_write(lrf_pkg::CFG_BASIC_MODE, 64'd0);
    queue_write(lrf_pkg::CFG_RANGE_LENGTH, 64'd0);
    load_tag_str("-a");
    queue_tag();

    phase = 0;
    while (tag_items < 480) begin
      if (phase == 2) begin
        // tag longer than the position counter's range
        load_range_str("ab");
        gen_basic = 1'b1;
        queue_range();
        load_tag_str("AB-");
        while (tag_buf.size() < 258) tag_buf.push_back(rand_alnum());
        queue_tag();
      end else begin
        gen_range();
        gen_basic = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick == 0) gen_len = 6'd0;
        else if (pick == 1) gen_len = 6'($urandom_range(33, 63));
        else if (pick == 2) gen_len = 6'd63;
        else gen_len = 6'(gen_range_n);
        queue_range();
        repeat ($urandom_range(3, 8)) begin
          if ($urandom_range(0, 7) == 0) gen_noise_tag();
          else gen_tag(gen_basic ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 5) == 0));
          queue_tag();
        end
      end
      phase++;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (plan.size() != 0 || in_tvalid || cfg_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
